>>> hw/rtl/mqr_pkg.sv
// Package for the message ring table: request and status codes, FSM states.
// Used by the top module multi_queue_message_ring; the RAM modules do not import it.
`default_nettype none
package mqr_pkg;
    localparam int MQR_NUM_QUEUES  = 64;
    localparam int MQR_QUEUE_BYTES = 1024;

    localparam logic [3:0] REQ_CREATE  = 4'd0;
    localparam logic [3:0] REQ_DESTROY = 4'd1;
    localparam logic [3:0] REQ_RENAME  = 4'd2;
    localparam logic [3:0] REQ_LOOKUP  = 4'd3;
    localparam logic [3:0] REQ_PEEK    = 4'd4;
    localparam logic [3:0] REQ_PUT     = 4'd5;
    localparam logic [3:0] REQ_PUTB    = 4'd6;
    localparam logic [3:0] REQ_GET     = 4'd7;
    localparam logic [3:0] REQ_GETB    = 4'd8;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NORES    = 3'd1;
    localparam logic [2:0] ST_NOTEXIST = 3'd2;
    localparam logic [2:0] ST_OVER     = 3'd3;
    localparam logic [2:0] ST_BUSY     = 3'd4;
    localparam logic [2:0] ST_NOXFER   = 3'd5;

    typedef enum logic [1:0] {
        M_IDLE,
        M_PUT,
        M_GET
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CSCAN,
        S_LREAD,
        S_LCMP,
        S_DESC,
        S_PUTHI,
        S_H0,
        S_H1,
        S_GETB
    } t_state;
endpackage
`default_nettype wire

>>> hw/rtl/mqr_byte_ram.sv
// Byte store of all rings: one write port, one registered read port.
// No package dependencies.
`default_nettype none
module mqr_byte_ram #(
    parameter int AW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [7:0]    o_rdata
);
    logic [7:0] mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> hw/rtl/mqr_desc_ram.sv
// Ring descriptors: name label and {write, read} pointer pair per ring.
// Two memories, each one write and one registered read port.
`default_nettype none
module mqr_desc_ram #(
    parameter int QW = 6,
    parameter int PW = 10
) (
    input  wire logic            i_clk,
    input  wire logic            i_lbl_we,
    input  wire logic [QW-1:0]   i_lbl_waddr,
    input  wire logic [15:0]     i_lbl_wdata,
    input  wire logic [QW-1:0]   i_lbl_raddr,
    output logic      [15:0]     o_lbl_rdata,
    input  wire logic            i_ptr_we,
    input  wire logic [QW-1:0]   i_ptr_waddr,
    input  wire logic [2*PW-1:0] i_ptr_wdata,
    input  wire logic [QW-1:0]   i_ptr_raddr,
    output logic      [2*PW-1:0] o_ptr_rdata
);
    logic [15:0]     lbl_mem [2**QW];
    logic [2*PW-1:0] ptr_mem [2**QW];

    always_ff @(posedge i_clk) begin
        if (i_lbl_we) begin
            lbl_mem[i_lbl_waddr] <= i_lbl_wdata;
        end
        o_lbl_rdata <= lbl_mem[i_lbl_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ptr_we) begin
            ptr_mem[i_ptr_waddr] <= i_ptr_wdata;
        end
        o_ptr_rdata <= ptr_mem[i_ptr_raddr];
    end
endmodule
`default_nettype wire

>>> hw/rtl/multi_queue_message_ring.sv
// Table of named byte rings holding length-prefixed messages.
// Input channel: i_in_valid/o_in_ready with request fields; output channel:
// o_out_valid/i_out_ready, exactly one result word per request word.
// One request is in work at a time. A request is taken in the idle state,
// even while the previous result still waits in the output register.
// Steps per request, from accept to result registered:
//   put byte, decode errors, destroy, rename: decode only
//   get byte: decode, then the registered byte store read
//   peek, get start: decode, descriptor read, then two header byte reads,
//   or the answer at the descriptor read on an empty ring
//   put start: decode, descriptor read, two header byte writes
//   create, lookup: decode, then a scan of ring ids from 1 up
// The FSM then returns to idle, where the next word is accepted.
// Create scans the active bits one id a cycle; lookup reads one label
// per id from the label memory, then compares it in a second state.
// Reset (i_rst_n low, synchronous) clears all active bits and closes any
// transfer; memories need no clearing since create writes the pointers.
// If the receiver stalls, a finished result is held and the next request
// waits at decode until the output register frees.
`default_nettype none
module multi_queue_message_ring
    import mqr_pkg::*;
#(
    parameter int NUM_QUEUES  = MQR_NUM_QUEUES,
    parameter int QUEUE_BYTES = MQR_QUEUE_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [3:0]  i_req_type,
    input  wire logic [5:0]  i_queue_id,
    input  wire logic [15:0] i_queue_name,
    input  wire logic [15:0] i_msg_size,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_status,
    output logic [15:0]      o_result_value,
    output logic [7:0]       o_out_byte,
    output logic             o_byte_kept,
    output logic             o_last
);
    localparam int QW = $clog2(NUM_QUEUES);
    localparam int PW = $clog2(QUEUE_BYTES);
    localparam int AW = QW + PW;
    localparam logic [PW-1:0] PTR_MAX = PW'(QUEUE_BYTES - 1);
    localparam logic [QW-1:0] ID_MAX  = QW'(NUM_QUEUES - 1);
    localparam logic [16:0]   QB1     = 17'(QUEUE_BYTES - 1);

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        return (p == PTR_MAX) ? '0 : p + PW'(1);
    endfunction

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    logic [3:0]  r_req;
    logic [5:0]  r_id;
    logic [15:0] r_name, r_size;
    logic [7:0]  r_data, r_lo, n_lo;
    logic [QW-1:0] r_k, n_k, r_xq, n_xq;
    logic [PW-1:0] r_xptr, n_xptr, r_xoth, n_xoth, r_p, n_p, r_w, n_w;
    logic [15:0] r_rem, n_rem, r_lim, n_lim;
    logic [NUM_QUEUES-1:0] r_active, n_active;

    logic        r_ov, n_ov;
    logic [2:0]  r_status;
    logic [15:0] r_val;
    logic [7:0]  r_ob;
    logic        r_kept, r_last;

    logic        emit;
    logic [2:0]  res_status;
    logic [15:0] res_val;
    logic [7:0]  res_ob;
    logic        res_kept, res_last;

    logic            b_we;
    logic [AW-1:0]   b_waddr, b_raddr;
    logic [7:0]      b_wdata, b_rdata;
    logic            l_we;
    logic [QW-1:0]   l_waddr;
    logic [15:0]     l_rdata;
    logic            p_we;
    logic [QW-1:0]   p_waddr;
    logic [2*PW-1:0] p_wdata, p_rdata;

    logic [QW-1:0] id_q;
    logic          id_ok, slot_free;
    logic [PW-1:0] d_wp, d_rp;
    logic [16:0]   rs, free_sp, wx, rx;
    logic [15:0]   rem_dec;

    mqr_byte_ram #(.AW(AW)) u_bytes (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    mqr_desc_ram #(.QW(QW), .PW(PW)) u_desc (
        .i_clk       (i_clk),
        .i_lbl_we    (l_we),
        .i_lbl_waddr (l_waddr),
        .i_lbl_wdata (r_name),
        .i_lbl_raddr (r_k),
        .o_lbl_rdata (l_rdata),
        .i_ptr_we    (p_we),
        .i_ptr_waddr (p_waddr),
        .i_ptr_wdata (p_wdata),
        .i_ptr_raddr (id_q),
        .o_ptr_rdata (p_rdata)
    );

    assign id_q      = QW'(r_id);
    assign id_ok     = (r_id != 6'd0) && (32'(r_id) < NUM_QUEUES) && r_active[id_q];
    assign slot_free = !r_ov || i_out_ready;
    assign d_wp      = p_rdata[2*PW-1:PW];
    assign d_rp      = p_rdata[PW-1:0];
    assign rs        = ({1'b0, r_size} + 17'd3) & ~17'd3;
    assign wx        = 17'(d_wp);
    assign rx        = 17'(d_rp);
    assign rem_dec   = r_rem - 16'd1;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        if (wx == rx) begin
            free_sp = QB1;
        end else if (rx < wx) begin
            free_sp = QB1 - wx + rx;
        end else begin
            free_sp = rx - 17'd1 - wx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_mode = r_mode;
        n_k = r_k;
        n_xq = r_xq;
        n_xptr = r_xptr;
        n_xoth = r_xoth;
        n_p = r_p;
        n_w = r_w;
        n_lo = r_lo;
        n_rem = r_rem;
        n_lim = r_lim;
        n_active = r_active;
        emit = 1'b0;
        res_status = ST_OK;
        res_val = '0;
        res_ob = '0;
        res_kept = 1'b0;
        res_last = 1'b0;
        b_we = 1'b0;
        b_waddr = {r_xq, r_xptr};
        b_wdata = r_data;
        b_raddr = {r_xq, r_xptr};
        l_we = 1'b0;
        l_waddr = r_k;
        p_we = 1'b0;
        p_waddr = r_xq;
        p_wdata = {r_xptr, r_xoth};

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                    if (r_req > REQ_GETB) begin
                        emit = 1'b1;
                        res_status = ST_NOTEXIST;
                    end else if (r_req == REQ_PUTB) begin
                        emit = 1'b1;
                        if (r_mode != M_PUT) begin
                            res_status = ST_NOXFER;
                        end else begin
                            b_we = 1'b1;
                            p_we = 1'b1;
                            p_wdata = {ring_next(r_xptr), r_xoth};
                            n_xptr = ring_next(r_xptr);
                            n_rem = rem_dec;
                            res_val = rem_dec;
                            if (rem_dec == 16'd0) begin
                                res_last = 1'b1;
                                n_mode = M_IDLE;
                            end
                        end
                    end else if (r_req == REQ_GETB) begin
                        if (r_mode != M_GET) begin
                            emit = 1'b1;
                            res_status = ST_NOXFER;
                        end else begin
                            n_state = S_GETB;
                        end
                    end else if (r_mode != M_IDLE) begin
                        emit = 1'b1;
                        res_status = ST_BUSY;
                    end else if (r_req == REQ_CREATE) begin
                        n_k = QW'(1);
                        n_state = S_CSCAN;
                    end else if (r_req == REQ_LOOKUP) begin
                        n_k = QW'(1);
                        n_state = S_LREAD;
                    end else if (!id_ok) begin
                        emit = 1'b1;
                        res_status = ST_NOTEXIST;
                    end else if (r_req == REQ_DESTROY) begin
                        emit = 1'b1;
                        n_active[id_q] = 1'b0;
                    end else if (r_req == REQ_RENAME) begin
                        emit = 1'b1;
                        l_we = 1'b1;
                        l_waddr = id_q;
                        res_val = 16'(r_id);
                    end else begin
                        // peek, put start, get start: fetch the pointers first
                        n_state = S_DESC;
                    end
                end
            end
            S_CSCAN: begin
                if (!r_active[r_k]) begin
                    emit = 1'b1;
                    n_state = S_IDLE;
                    n_active[r_k] = 1'b1;
                    l_we = 1'b1;
                    p_we = 1'b1;
                    p_waddr = r_k;
                    p_wdata = '0;
                    res_val = 16'(r_k);
                end else if (r_k == ID_MAX) begin
                    emit = 1'b1;
                    n_state = S_IDLE;
                    res_status = ST_NORES;
                end else begin
                    n_k = r_k + QW'(1);
                end
            end
            S_LREAD: begin
                n_state = S_LCMP;
            end
            S_LCMP: begin
                if (r_active[r_k] && (l_rdata == r_name)) begin
                    emit = 1'b1;
                    n_state = S_IDLE;
                    res_val = 16'(r_k);
                end else if (r_k == ID_MAX) begin
                    emit = 1'b1;
                    n_state = S_IDLE;
                    res_status = ST_NOTEXIST;
                end else begin
                    n_k = r_k + QW'(1);
                    n_state = S_LREAD;
                end
            end
            S_DESC: begin
                if (r_req == REQ_PUT) begin
                    if (rs == 17'd0 || rs > free_sp) begin
                        emit = 1'b1;
                        n_state = S_IDLE;
                        res_status = ST_OVER;
                    end else begin
                        b_we = 1'b1;
                        b_waddr = {id_q, d_wp};
                        b_wdata = rs[7:0];
                        n_p = ring_next(d_wp);
                        n_w = d_rp;
                        n_state = S_PUTHI;
                    end
                end else if (d_wp == d_rp) begin
                    emit = 1'b1;
                    n_state = S_IDLE;
                    res_status = ST_OVER;
                end else begin
                    b_raddr = {id_q, d_rp};
                    n_p = d_rp;
                    n_w = d_wp;
                    n_state = S_H0;
                end
            end
            S_PUTHI: begin
                emit = 1'b1;
                n_state = S_IDLE;
                b_we = 1'b1;
                b_waddr = {id_q, r_p};
                b_wdata = rs[15:8];
                p_we = 1'b1;
                p_waddr = id_q;
                p_wdata = {ring_next(r_p), r_w};
                n_xq = id_q;
                n_xptr = ring_next(r_p);
                n_xoth = r_w;
                n_rem = rs[15:0] - 16'd2;
                n_mode = M_PUT;
                res_val = rs[15:0];
            end
            S_H0: begin
                n_lo = b_rdata;
                b_raddr = {id_q, ring_next(r_p)};
                n_state = S_H1;
            end
            S_H1: begin
                emit = 1'b1;
                n_state = S_IDLE;
                res_val = {b_rdata, r_lo};
                if (r_req == REQ_GET && {b_rdata, r_lo} != 16'd0) begin
                    n_rem = {b_rdata, r_lo};
                    n_lim = r_size;
                    n_xq = id_q;
                    n_xptr = r_p;
                    n_xoth = r_w;
                    n_mode = M_GET;
                end
            end
            S_GETB: begin
                emit = 1'b1;
                n_state = S_IDLE;
                res_ob = b_rdata;
                if (r_lim != 16'd0) begin
                    res_kept = 1'b1;
                    n_lim = r_lim - 16'd1;
                end
                // get mode: xptr is the read pointer, xoth the write pointer
                p_we = 1'b1;
                p_wdata = {r_xoth, ring_next(r_xptr)};
                n_xptr = ring_next(r_xptr);
                n_rem = rem_dec;
                res_val = rem_dec;
                if (rem_dec == 16'd0) begin
                    res_last = 1'b1;
                    n_mode = M_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_ov = (r_ov && !i_out_ready) || emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode <= M_IDLE;
            r_active <= '0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode <= n_mode;
            r_active <= n_active;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_req <= i_req_type;
            r_id <= i_queue_id;
            r_name <= i_queue_name;
            r_size <= i_msg_size;
            r_data <= i_data_byte;
        end
        r_k <= n_k;
        r_xq <= n_xq;
        r_xptr <= n_xptr;
        r_xoth <= n_xoth;
        r_p <= n_p;
        r_w <= n_w;
        r_lo <= n_lo;
        r_rem <= n_rem;
        r_lim <= n_lim;
        if (emit) begin
            r_status <= res_status;
            r_val <= res_val;
            r_ob <= res_ob;
            r_kept <= res_kept;
            r_last <= res_last;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_status       = r_status;
    assign o_result_value = r_val;
    assign o_out_byte     = r_ob;
    assign o_byte_kept    = r_kept;
    assign o_last         = r_last;
endmodule
`default_nettype wire
